// File: design/isqrt_rem_128_defines.svh
// Assertion macros shared by the checker of the 128-bit square root block.
// No dependencies; included by files that assert.
`ifndef ISQRT_REM_128_DEFINES_SVH
`define ISQRT_REM_128_DEFINES_SVH

// Checks that the antecedent implies the consequent in the next cycle.
`define ISQRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checks that an expression never holds in any cycle out of reset.
`define ISQRT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// File: design/isqrt_pkg.sv
// Package for the 128-bit square root block: request and response types,
// remainder size codes and sequencer states. No dependencies.
`timescale 1ns / 1ps

package isqrt_pkg;

  localparam int unsigned DATA_W = 64;

  typedef struct packed {
    logic [DATA_W-1:0] n_high;
    logic [DATA_W-1:0] n_low;
  } isqrt_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] root;
    logic [DATA_W-1:0] rem_low;
    logic              rem_high;
    logic [1:0]        rem_size;
  } isqrt_rsp_t;

  localparam logic [1:0] REM_SIZE_ZERO = 2'd0;
  localparam logic [1:0] REM_SIZE_LOW  = 2'd1;
  localparam logic [1:0] REM_SIZE_HIGH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } isqrt_state_e;

endpackage

// File: design/isqrt_step.sv
// One restoring square root step: shifts a digit pair into the partial
// remainder, compares against 4s+1 and subtracts. Uses no package.
`timescale 1ns / 1ps

module isqrt_step #(
  parameter int unsigned ROOT_BITS = 64
) (
  input  logic [ROOT_BITS:0]   rem_i,
  input  logic [ROOT_BITS-1:0] root_i,
  input  logic [1:0]           pair_i,
  output logic [ROOT_BITS:0]   rem_o,
  output logic [ROOT_BITS-1:0] root_o
);

  logic [ROOT_BITS+2:0] shifted;
  logic [ROOT_BITS+2:0] trial;
  logic [ROOT_BITS+2:0] diff;
  logic                 ge;

  assign shifted = {rem_i, pair_i};
  assign trial   = {1'b0, root_i, 2'b01};
  assign diff    = shifted - trial;
  assign ge      = (shifted >= trial);
  assign rem_o   = ge ? diff[ROOT_BITS:0] : shifted[ROOT_BITS:0];
  assign root_o  = {root_i[ROOT_BITS-2:0], ge};

endmodule

// File: design/isqrt_rem_128.sv
// Top level of the 128-bit integer square root with remainder.
// Depends on isqrt_pkg and isqrt_step.
`timescale 1ns / 1ps

// A request is taken only while the block is idle. The root is built one bit
// per cycle by a single compare-and-subtract unit while the block is busy,
// after which the response is held until it is taken. No new request is
// accepted until that response has been taken. Radicand bits at and above
// position 2*ROOT_BITS are ignored.
module isqrt_rem_128 #(
  parameter int unsigned ROOT_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  isqrt_pkg::isqrt_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output isqrt_pkg::isqrt_rsp_t out_rsp_o
);

  import isqrt_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_BITS);

  isqrt_state_e             state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [2*ROOT_BITS-1:0]   n_q, n_d;
  logic [ROOT_BITS:0]       rem_q, rem_d, rem_step;
  logic [ROOT_BITS-1:0]     root_q, root_d, root_step;
  logic [2*DATA_W-1:0]      n_full;
  logic [DATA_W:0]          rem_ext;

  assign n_full = {in_req_i.n_high, in_req_i.n_low};

  isqrt_step #(
    .ROOT_BITS(ROOT_BITS)
  ) u_step (
    .rem_i  (rem_q),
    .root_i (root_q),
    .pair_i (n_q[2*ROOT_BITS-1 -: 2]),
    .rem_o  (rem_step),
    .root_o (root_step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    rem_d       = rem_q;
    root_d      = root_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          n_d     = n_full[2*ROOT_BITS-1:0];
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = CNT_W'(ROOT_BITS - 1);
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        n_d    = {n_q[2*ROOT_BITS-3:0], 2'b00};
        rem_d  = rem_step;
        root_d = root_step;
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rem_ext = (DATA_W + 1)'(rem_q);

  always_comb begin
    out_rsp_o.root     = DATA_W'(root_q);
    out_rsp_o.rem_low  = rem_ext[DATA_W-1:0];
    out_rsp_o.rem_high = rem_ext[DATA_W];
    if (rem_ext[DATA_W]) begin
      out_rsp_o.rem_size = REM_SIZE_HIGH;
    end else if (rem_ext[DATA_W-1:0] != '0) begin
      out_rsp_o.rem_size = REM_SIZE_LOW;
    end else begin
      out_rsp_o.rem_size = REM_SIZE_ZERO;
    end
  end

endmodule

// File: design/isqrt_chk.sv
// Port-level checker for the 128-bit square root block, bound to its top level.
// Depends on isqrt_pkg and isqrt_rem_128_defines.svh.
`timescale 1ns / 1ps
`include "isqrt_rem_128_defines.svh"

module isqrt_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input isqrt_pkg::isqrt_rsp_t out_rsp_i
);

  import isqrt_pkg::*;

  // A held response must keep its value until it is taken.
  `ISQRT_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_rsp_i), "response dropped or changed while stalled")

  // The block never accepts a request while a response is pending.
  `ISQRT_ASSERT_NEVER(a_busy_excl, clk_i, rst_ni, in_ready_i && out_valid_i, "ready while a response is pending")

  // An accepted request cannot produce its response in the next cycle.
  `ISQRT_ASSERT_NEXT(a_no_early, clk_i, rst_ni, in_valid_i && in_ready_i, !out_valid_i && !in_ready_i, "response or ready too soon after a request")

  // A response that has been taken is not repeated.
  `ISQRT_ASSERT_NEXT(a_single_rsp, clk_i, rst_ni, out_valid_i && out_ready_i, !out_valid_i, "response repeated")

endmodule

bind isqrt_rem_128 isqrt_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_i   (out_rsp_o)
);

// File: verif/isqrt_rem_128_tb.sv
// Self-checking testbench for isqrt_rem_128: directed and random radicands
// are checked against a bit-level square root predictor. Depends on isqrt_pkg.
`timescale 1ns / 1ps

module isqrt_rem_128_tb;
  import isqrt_pkg::*;

  localparam int unsigned CLK_HALF       = 4;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned RANDOM_ITEMS   = 600;
  localparam int unsigned IDLE_PERCENT   = 11;
  localparam int unsigned CALM_LO        = 200;
  localparam int unsigned CALM_HI        = 300;
  localparam int unsigned DRAIN_AT_A     = 25;
  localparam int unsigned DRAIN_AT_B     = 400;
  localparam int unsigned HOLD_AT        = 60;
  localparam int unsigned HOLD_CYCLES    = 500;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 200;

  typedef struct {
    isqrt_req_t req;
    bit         drain;
    bit         calm;
  } radicand_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  isqrt_req_t in_req = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  isqrt_rsp_t out_rsp;

  radicand_item_t pending_radicands[$];
  isqrt_rsp_t     expected_sqrt_q[$];
  int unsigned    sent_cnt = 0;
  int unsigned    recv_cnt = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    mismatch_count = 0;
  int unsigned    hold_left = 0;
  bit             hold_done = 1'b0;

  isqrt_rem_128 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Restoring digit recurrence: one root bit per radicand digit pair.
  function automatic isqrt_rsp_t floor_sqrt_rem(isqrt_req_t req);
    logic [127:0] rad;
    logic [66:0]  part;
    logic [66:0]  trial;
    logic [63:0]  root;
    isqrt_rsp_t   rsp;
    rad  = {req.n_high, req.n_low};
    part = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      part  = {part[64:0], rad[2*i +: 2]};
      trial = {1'b0, root, 2'b01};
      if (part >= trial) begin
        part = part - trial;
        root = {root[62:0], 1'b1};
      end else begin
        root = {root[62:0], 1'b0};
      end
    end
    rsp.root     = root;
    rsp.rem_low  = part[63:0];
    rsp.rem_high = part[64];
    if (part[64]) begin
      rsp.rem_size = REM_SIZE_HIGH;
    end else if (part[63:0] != '0) begin
      rsp.rem_size = REM_SIZE_LOW;
    end else begin
      rsp.rem_size = REM_SIZE_ZERO;
    end
    return rsp;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_radicand(input logic [127:0] rad);
    radicand_item_t item;
    item.req   = isqrt_req_t'(rad);
    item.drain = (pending_radicands.size() == DRAIN_AT_A) ||
                 (pending_radicands.size() == DRAIN_AT_B);
    item.calm  = (pending_radicands.size() >= CALM_LO) &&
                 (pending_radicands.size() < CALM_HI);
    pending_radicands.push_back(item);
  endtask

  // Request driver. Before an item marked for draining, it waits until every
  // response that is still owed has come back.
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned sent_now;
    bit          fire;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
      sent_cnt <= 0;
    end else begin
      sent_now = sent_cnt;
      if (in_valid && in_ready) begin
        expected_sqrt_q.push_back(floor_sqrt_rem(in_req));
        sent_now = sent_cnt + 1;
        sent_cnt <= sent_now;
      end
      if (!in_valid || in_ready) begin
        fire = 1'b0;
        if (pending_radicands.size() != 0) begin
          fire = 1'b1;
          if (pending_radicands[0].drain && (recv_cnt != sent_now)) begin
            fire = 1'b0;
          end else if (!pending_radicands[0].calm &&
                       ($urandom_range(99, 0) < IDLE_PERCENT)) begin
            fire = 1'b0;
          end
        end
        if (fire) begin
          in_valid <= 1'b1;
          in_req   <= pending_radicands[0].req;
          pending_radicands.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and checker, with one long hold-off of the ready.
  always @(posedge clk_i or negedge rst_ni) begin
    isqrt_rsp_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_cnt  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        recv_cnt <= recv_cnt + 1;
        if (expected_sqrt_q.size() == 0) begin
          $error("unexpected response: root %h rem_low %h", out_rsp.root, out_rsp.rem_low);
          mismatch_count++;
        end else begin
          want = expected_sqrt_q.pop_front();
          if (out_rsp.root !== want.root) begin
            $error("root: expected %h, actual %h", want.root, out_rsp.root);
            mismatch_count++;
          end
          if (out_rsp.rem_low !== want.rem_low) begin
            $error("rem_low: expected %h, actual %h", want.rem_low, out_rsp.rem_low);
            mismatch_count++;
          end
          if (out_rsp.rem_high !== want.rem_high) begin
            $error("rem_high: expected %b, actual %b", want.rem_high, out_rsp.rem_high);
            mismatch_count++;
          end
          if (out_rsp.rem_size !== want.rem_size) begin
            $error("rem_size: expected %0d, actual %0d", want.rem_size, out_rsp.rem_size);
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && (recv_cnt == HOLD_AT)) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if ((recv_cnt >= CALM_LO) && (recv_cnt < CALM_HI)) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0]  s;
    logic [127:0] sq;
    logic [127:0] rad;
    logic [127:0] span;
    int unsigned  total_items;
    bit           timed_out;

    add_radicand(128'd0);
    add_radicand(128'd1);
    add_radicand(128'd2);
    add_radicand(128'd3);
    add_radicand(128'd4);
    add_radicand(128'd8);
    add_radicand(128'd99);
    add_radicand(128'd100);
    add_radicand({128{1'b1}});
    add_radicand({128{1'b1}} - 128'd1);
    add_radicand(128'd1 << 127);
    add_radicand(128'd1 << 126);
    sq = {64'd0, {64{1'b1}}} * {64'd0, {64{1'b1}}};
    add_radicand(sq);
    add_radicand(sq - 128'd1);
    add_radicand(128'd1 << 64);
    add_radicand({64'd0, {64{1'b1}}});
    add_radicand({{32{2'b10}}, {32{2'b01}}});
    add_radicand({{32{2'b01}}, {32{2'b10}}});
    // A remainder of exactly 2^64 sets the high remainder bit with a zero low limb.
    add_radicand((128'd1 << 126) + (128'd1 << 64));
    add_radicand((128'd1 << 126) + (128'd1 << 64) - 128'd1);
    add_radicand({64'd0, rand64()});

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      s  = rand64() >> $urandom_range(63, 0);
      sq = {64'd0, s} * {64'd0, s};
      case ($urandom_range(19, 0))
        0, 1, 2, 3, 4, 5: rad = {rand64(), rand64()};
        6, 7, 8:          rad = sq;
        9, 10, 11:        rad = sq + ({64'd0, s} << 1);
        12, 13: begin
          span = ({64'd0, s} << 1) + 128'd1;
          rad  = sq + ({rand64(), rand64()} % span);
        end
        14, 15, 16:       rad = {rand64(), rand64()} >> $urandom_range(127, 0);
        17, 18:           rad = {64'd0, rand64()};
        default:          rad = ~({64'd0, rand64()} >> $urandom_range(63, 0));
      endcase
      add_radicand(rad);
    end
    total_items = pending_radicands.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    timed_out = 1'b0;
    while (!timed_out && !((sent_cnt == total_items) && (recv_cnt == sent_cnt))) begin
      @(posedge clk_i);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
      end
    end
    if (!timed_out) begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
    end
    if (expected_sqrt_q.size() != 0) begin
      $error("%0d responses never arrived", expected_sqrt_q.size());
      mismatch_count++;
    end

    if (!timed_out && (mismatch_count == 0)) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
